>>> design/bwph_pkg.sv
package bwph_pkg;
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_HEIGHT = 2'd3;
  localparam int CFG_DATA_BITS = 13;
  localparam int CODE_BITS = 9;
  localparam int BINS = 512;
  localparam int OUT_BITS = 32;
  localparam int IN_DATA_BITS = 24;
  localparam int OUT_DATA_BITS = 48;

  // classified work item between front and back
  typedef struct packed {
    logic                 is_read;
    logic                 counted;
    logic [CODE_BITS-1:0] code;
  } bwph_op_t;
endpackage

>>> design/binary_window_pattern_histogram.sv
// binary window pattern histogram: pixels (tuser=0) are thresholded to one bit
// and each full window ending at the pixel increments a saturating bin; a read
// request (tuser=1) returns one bin. one result beat per input beat, one item
// per cycle while m_tready is high; beats pass the window front stage, histogram
// read stage and output register. after reset a clearing pass writes one bin per
// cycle over all 512 bins, and no beat reaches the histogram before it ends.
module binary_window_pattern_histogram #(
  parameter int MAX_WINDOW_W = 3,
  parameter int MAX_WINDOW_H = 3,
  parameter int MAX_IMAGE_W  = 4096,
  parameter int COUNT_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // pixel_value[7:0], bin_index[16:8], zero fill
  input  logic        s_tuser,  // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // pattern_code[8:0], bin_count[40:9], zero fill
  output logic [1:0]  m_tuser,  // window_complete, is_read_reply
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import bwph_pkg::*;

  logic [12:0] image_width, image_height;
  logic [1:0] window_width, window_height;
  logic op_valid, op_ready;
  bwph_op_t op;
  logic [8:0] pattern_code;
  logic [31:0] bin_count;
  logic window_complete, is_read_reply;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd640; image_height <= 13'd480;
      window_width <= 2'd2; window_height <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height <= cfg_data;
        REG_WINDOW_WIDTH:  window_width <= cfg_data[1:0];
        REG_WINDOW_HEIGHT: window_height <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  bwph_front #(.MAX_WINDOW_W(MAX_WINDOW_W), .MAX_WINDOW_H(MAX_WINDOW_H),
               .MAX_IMAGE_W(MAX_IMAGE_W)) u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .req_type(s_tuser),
    .pixel_value(s_tdata[7:0]), .bin_index(s_tdata[16:8]),
    .image_width, .image_height, .window_width, .window_height,
    .op_valid, .op_ready, .op);

  bwph_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst, .op_valid, .op_ready, .op, .res_valid(m_tvalid), .res_ready(m_tready),
    .pattern_code, .bin_count, .window_complete, .is_read_reply);

  assign m_tdata = {7'd0, bin_count, pattern_code};
  assign m_tuser = {is_read_reply, window_complete};
endmodule

>>> design/bwph_front.sv
module bwph_front #(
  parameter int MAX_WINDOW_W = 3,
  parameter int MAX_WINDOW_H = 3,
  parameter int MAX_IMAGE_W  = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      req_type,
  input  logic [7:0]                pixel_value,
  input  logic [8:0]                bin_index,
  input  logic [12:0]               image_width,
  input  logic [12:0]               image_height,
  input  logic [1:0]                window_width,
  input  logic [1:0]                window_height,
  output logic                      op_valid,
  input  logic                      op_ready,
  output bwph_pkg::bwph_op_t        op
);
  import bwph_pkg::*;

  localparam int XB = $clog2(MAX_IMAGE_W);
  localparam int RB = (MAX_WINDOW_H > 1) ? $clog2(MAX_WINDOW_H) : 1;
  localparam int WB = MAX_WINDOW_W * MAX_WINDOW_H;

  logic [XB-1:0] col;
  logic [XB-1:0] col_next;
  logic [11:0]   row;
  logic [RB-1:0] slot;
  // sliding window: row r (0 = top) column c (0 = left)
  logic [MAX_WINDOW_W-1:0] win [MAX_WINDOW_H];
  logic [MAX_WINDOW_W-1:0] win_next [MAX_WINDOW_H];
  logic rd_bit [MAX_WINDOW_H];
  // registered line memory reads, one per buffered row, at the next column
  logic rd_q [MAX_WINDOW_H];

  logic [13:0] w, h;
  logic [2:0]  ww, wh;
  logic        take, pix_bit, counted, last_col;
  logic [WB-1:0] code_full;
  logic [CODE_BITS-1:0] code;
  logic [RB-1:0] src_slot;
  int slot_sum;

  assign take = in_valid && in_ready;
  assign in_ready = !op_valid || op_ready;
  assign pix_bit = (pixel_value != 8'd0);

  always_comb begin
    w = (image_width == 13'd0) ? 14'd1 :
        ({1'b0, image_width} > 14'(MAX_IMAGE_W)) ? 14'(MAX_IMAGE_W) : {1'b0, image_width};
    h = (image_height == 13'd0) ? 14'd1 :
        ({1'b0, image_height} > 14'd4096) ? 14'd4096 : {1'b0, image_height};
    ww = (window_width == 2'd0) ? 3'd1 :
         ({1'b0, window_width} > 3'(MAX_WINDOW_W)) ? 3'(MAX_WINDOW_W) : {1'b0, window_width};
    wh = (window_height == 2'd0) ? 3'd1 :
         ({1'b0, window_height} > 3'(MAX_WINDOW_H)) ? 3'(MAX_WINDOW_H) : {1'b0, window_height};
  end

  always_comb begin
    col_next = col;
    if (take && !req_type) col_next = last_col ? '0 : col + XB'(1);
  end

  // one line memory per buffered row, read one column ahead
  for (genvar s = 0; s < MAX_WINDOW_H; s++) begin : g_line
    logic lbuf [MAX_IMAGE_W];
    always_ff @(posedge clk) begin
      if (take && !req_type && slot == RB'(s)) lbuf[col] <= pix_bit;
      if (take && !req_type && slot == RB'(s) && col_next == col) rd_q[s] <= pix_bit;
      else rd_q[s] <= lbuf[col_next];
    end
  end

  // pick the buffered row that sits at each window row
  always_comb begin
    for (int r = 0; r < MAX_WINDOW_H; r++) begin
      slot_sum = 32'(slot) + 32'(MAX_WINDOW_H) + 1 - 32'(wh) + 32'(r);
      if (slot_sum >= MAX_WINDOW_H) slot_sum = slot_sum - MAX_WINDOW_H;
      if (slot_sum >= MAX_WINDOW_H) slot_sum = slot_sum - MAX_WINDOW_H;
      src_slot = RB'(slot_sum);
      rd_bit[r] = rd_q[src_slot];
    end
  end

  // window bits shift left by one column; newest column enters at ww-1
  always_comb begin
    for (int r = 0; r < MAX_WINDOW_H; r++) begin
      for (int c = 0; c < MAX_WINDOW_W; c++) begin
        if (c + 1 < MAX_WINDOW_W) win_next[r][c] = win[r][c+1];
        else win_next[r][c] = 1'b0;
        if (c == 32'(ww) - 1) begin
          if (r == 32'(wh) - 1) win_next[r][c] = pix_bit;
          else win_next[r][c] = rd_bit[r];
        end
      end
    end
    code_full = '0;
    for (int r = 0; r < MAX_WINDOW_H; r++)
      for (int c = 0; c < MAX_WINDOW_W; c++)
        if (r < 32'(wh) && c < 32'(ww))
          code_full[r*32'(ww)+c] = win_next[r][c];
    code = CODE_BITS'(code_full);
    counted = ({2'b0, col} < w) && ({2'b0, row} < h) &&
              ({2'b0, col} + 1 >= 14'(ww)) && ({2'b0, row} + 1 >= 14'(wh));
    last_col = ({2'b0, col} + 1 >= w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0; slot <= '0; op_valid <= 1'b0;
      for (int r = 0; r < MAX_WINDOW_H; r++) win[r] <= '0;
    end else begin
      if (in_ready) op_valid <= in_valid;
      if (take) begin
        op.is_read <= req_type;
        op.counted <= !req_type && counted;
        op.code    <= req_type ? bin_index : (counted ? code : '0);
        if (!req_type) begin
          for (int r = 0; r < MAX_WINDOW_H; r++) win[r] <= win_next[r];
          if (last_col) begin
            col <= '0;
            for (int r = 0; r < MAX_WINDOW_H; r++) win[r] <= '0;
            if ({2'b0, row} + 1 >= h) begin
              row <= '0; slot <= '0;
            end else begin
              row <= row + 12'd1;
              slot <= (32'(slot) == MAX_WINDOW_H - 1) ? '0 : slot + RB'(1);
            end
          end else begin
            col <= col + XB'(1);
          end
        end
      end
    end
  end
endmodule

>>> design/bwph_back.sv
module bwph_back #(
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_ready,
  input  bwph_pkg::bwph_op_t op,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [8:0]         pattern_code,
  output logic [31:0]        bin_count,
  output logic               window_complete,
  output logic               is_read_reply
);
  import bwph_pkg::*;

  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [COUNT_BITS-1:0] hist [BINS];
  logic [COUNT_BITS-1:0] rd_raw, cur, inc;
  // stage two: read data and forwarding from the last update
  logic s2_valid;
  bwph_op_t s2;
  logic [CODE_BITS-1:0] last_code;
  logic last_wr;
  logic [COUNT_BITS-1:0] last_val;
  logic adv, take;
  // clearing pass after reset, one bin per cycle
  logic clr_busy;
  logic [CODE_BITS-1:0] clr_addr;

  assign adv = !res_valid || res_ready;
  assign op_ready = adv && !clr_busy;
  assign take = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (take) rd_raw <= hist[op.code];
  end

  always_comb begin
    if (last_wr && last_code == s2.code) cur = last_val;
    else cur = rd_raw;
    inc = (cur == CMAX) ? cur : cur + COUNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (clr_busy) hist[clr_addr] <= '0;
    else if (s2_valid && s2.counted && adv) hist[s2.code] <= inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0; res_valid <= 1'b0; last_wr <= 1'b0;
      clr_busy <= 1'b1; clr_addr <= '0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + CODE_BITS'(1);
        if (clr_addr == CODE_BITS'(BINS - 1)) clr_busy <= 1'b0;
      end
      if (adv) begin
        s2_valid <= take;
        if (take) s2 <= op;
        res_valid <= s2_valid;
        last_wr <= 1'b0;
        if (s2_valid) begin
          pattern_code    <= s2.code;
          window_complete <= s2.counted;
          is_read_reply   <= s2.is_read;
          if (s2.counted) begin
            last_wr <= 1'b1; last_code <= s2.code; last_val <= inc;
            bin_count <= (COUNT_BITS > 32 && (inc >> 32) != '0) ? '1 : 32'(inc);
          end else if (s2.is_read) begin
            bin_count <= (COUNT_BITS > 32 && (cur >> 32) != '0) ? '1 : 32'(cur);
          end else begin
            bin_count <= '0;
          end
        end
      end
    end
  end
endmodule
